// File: hw/rtl/dpb_pkg.sv
// shared widths, register codes, reset values and types for the depth pixel back-projector
`default_nettype none

package dpb_pkg;

    localparam int DepthW   = 16;
    localparam int PixW     = 11;
    localparam int ColorW   = 8;
    localparam int PrincW   = 15;
    localparam int RecipW   = 24;
    localparam int CoordW   = 24;
    localparam int ZW       = 23;
    localparam int FracPixW = 4;

    localparam int ProdW    = DepthW + RecipW;
    localparam int ZShift   = 8;
    localparam int ZRndW    = ProdW + 1 - ZShift;
    localparam int MagW     = PrincW;
    localparam int AW       = MagW + ZW;
    localparam int SplitW   = 19;
    localparam int HiW      = AW - SplitW;
    localparam int PartW    = SplitW + RecipW;
    localparam int MW       = 62;
    localparam int AxisShift = 28;
    localparam int RoundW   = MW + 1 - AxisShift;
    localparam int Stages   = 6;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] RegPrincX = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegPrincY = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegRecipFx = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegRecipFy = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] RegRecipScale = CfgIdxW'(4);

    localparam logic [PrincW-1:0] PrincXReset = PrincW'(5208);
    localparam logic [PrincW-1:0] PrincYReset = PrincW'(4056);
    localparam logic [RecipW-1:0] RecipFxReset = RecipW'(32389);
    localparam logic [RecipW-1:0] RecipFyReset = RecipW'(32326);
    localparam logic [RecipW-1:0] RecipScaleReset = RecipW'(16777);

    localparam logic [ProdW:0]    ZHalf    = (ProdW + 1)'(1) << (ZShift - 1);
    localparam logic [ZRndW-1:0]  ZMax     = ZRndW'((64'd1 << ZW) - 64'd1);
    localparam logic [MW:0]       AxisHalf = (MW + 1)'(1) << (AxisShift - 1);
    localparam logic [RoundW-1:0] PosLimit = RoundW'((64'd1 << (CoordW - 1)) - 64'd1);
    localparam logic [RoundW-1:0] NegLimit = RoundW'(64'd1 << (CoordW - 1));

    typedef struct packed {
        logic [ColorW-1:0] blue;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [PrincW-1:0] princ;
        logic [RecipW-1:0] recip;
    } t_axis_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/dpb_pix_if.sv
// pixel input channel: valid/ready with depth, position and colour
`default_nettype none

interface dpb_pix_if;
    logic                             valid;
    logic                             ready;
    logic [dpb_pkg::DepthW-1:0]       depth_raw;
    logic [dpb_pkg::PixW-1:0]         column;
    logic [dpb_pkg::PixW-1:0]         row;
    logic [dpb_pkg::ColorW-1:0]       blue_in;
    logic [dpb_pkg::ColorW-1:0]       green_in;
    logic [dpb_pkg::ColorW-1:0]       red_in;

    modport source (output valid, depth_raw, column, row, blue_in, green_in, red_in,
                    input ready);
    modport sink (input valid, depth_raw, column, row, blue_in, green_in, red_in,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dpb_pt_if.sv
// point output channel: valid/ready with coordinates and colour
`default_nettype none

interface dpb_pt_if;
    logic                               valid;
    logic                               ready;
    logic signed [dpb_pkg::CoordW-1:0]  point_x;
    logic signed [dpb_pkg::CoordW-1:0]  point_y;
    logic [dpb_pkg::ZW-1:0]             point_z;
    logic [dpb_pkg::ColorW-1:0]         blue_out;
    logic [dpb_pkg::ColorW-1:0]         green_out;
    logic [dpb_pkg::ColorW-1:0]         red_out;

    modport source (output valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dpb_cfg_if.sv
// configuration write channel: valid/ready with register index and data
`default_nettype none

interface dpb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpb_pkg::CfgIdxW-1:0]    index;
    logic [dpb_pkg::CfgDataW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dpb_depth.sv
// depth scaling: two stages, multiply by reciprocal scale then round and saturate
`default_nettype none

module dpb_depth (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [dpb_pkg::DepthW-1:0]     i_depth,
    input  wire logic [dpb_pkg::RecipW-1:0]     i_recip_scale,
    output logic      [dpb_pkg::ZW-1:0]         o_z
);

    logic [dpb_pkg::ProdW-1:0] r_p;
    logic [dpb_pkg::ZW-1:0]    r_z;
    logic [dpb_pkg::ZW-1:0]    n_z;
    logic [dpb_pkg::ProdW:0]   rnd_sum;
    logic [dpb_pkg::ZRndW-1:0] rnd;

    always_comb begin
        rnd_sum = {1'b0, r_p} + dpb_pkg::ZHalf;
        rnd     = rnd_sum[dpb_pkg::ProdW:dpb_pkg::ZShift];
        if (rnd > dpb_pkg::ZMax) begin
            n_z = dpb_pkg::ZMax[dpb_pkg::ZW-1:0];
        end else begin
            n_z = rnd[dpb_pkg::ZW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= dpb_pkg::ProdW'(i_depth) * dpb_pkg::ProdW'(i_recip_scale);
            r_z <= n_z;
        end
    end

    assign o_z = r_z;

endmodule

`default_nettype wire

// File: hw/rtl/dpb_axis.sv
// one lateral axis: offset, multiply by depth, split multiply by reciprocal focal, round
`default_nettype none

module dpb_axis (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic [dpb_pkg::PixW-1:0]           i_pix,
    input  wire dpb_pkg::t_axis_cfg                 i_cfg,
    input  wire logic [dpb_pkg::ZW-1:0]             i_z,
    output logic signed [dpb_pkg::CoordW-1:0]       o_coord
);

    logic [dpb_pkg::PrincW-1:0]  pos;
    logic                        n_neg;
    logic [dpb_pkg::MagW-1:0]    n_mag;

    logic [dpb_pkg::MagW-1:0]    r_mag1;
    logic [dpb_pkg::MagW-1:0]    r_mag2;
    logic [dpb_pkg::AW-1:0]      r_a3;
    logic [dpb_pkg::PartW-1:0]   r_hi4;
    logic [dpb_pkg::PartW-1:0]   r_lo4;
    logic [dpb_pkg::MW-1:0]      r_m5;
    logic [4:0]                  r_neg;
    logic signed [dpb_pkg::CoordW-1:0] r_coord6;

    logic [dpb_pkg::MW:0]        rnd_sum;
    logic [dpb_pkg::RoundW-1:0]  rnd;
    logic [dpb_pkg::CoordW-1:0]  sat_mag;
    logic signed [dpb_pkg::CoordW-1:0] n_coord;

    always_comb begin
        pos   = {i_pix, dpb_pkg::FracPixW'(0)};
        n_neg = pos < i_cfg.princ;
        if (n_neg) begin
            n_mag = i_cfg.princ - pos;
        end else begin
            n_mag = pos - i_cfg.princ;
        end
    end

    // round half away from zero, then saturate per sign
    always_comb begin
        rnd_sum = {1'b0, r_m5} + dpb_pkg::AxisHalf;
        rnd     = rnd_sum[dpb_pkg::MW:dpb_pkg::AxisShift];
        sat_mag = rnd[dpb_pkg::CoordW-1:0];
        if (r_neg[4]) begin
            if (rnd > dpb_pkg::NegLimit) begin
                sat_mag = dpb_pkg::NegLimit[dpb_pkg::CoordW-1:0];
            end
            n_coord = -$signed(sat_mag);
        end else begin
            if (rnd > dpb_pkg::PosLimit) begin
                sat_mag = dpb_pkg::PosLimit[dpb_pkg::CoordW-1:0];
            end
            n_coord = $signed(sat_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag1   <= n_mag;
            r_mag2   <= r_mag1;
            r_a3     <= dpb_pkg::AW'(r_mag2) * dpb_pkg::AW'(i_z);
            r_hi4    <= dpb_pkg::PartW'(r_a3[dpb_pkg::AW-1:dpb_pkg::SplitW])
                        * dpb_pkg::PartW'(i_cfg.recip);
            r_lo4    <= dpb_pkg::PartW'(r_a3[dpb_pkg::SplitW-1:0])
                        * dpb_pkg::PartW'(i_cfg.recip);
            r_m5     <= (dpb_pkg::MW'(r_hi4) << dpb_pkg::SplitW) + dpb_pkg::MW'(r_lo4);
            r_neg    <= {r_neg[3:0], n_neg};
            r_coord6 <= n_coord;
        end
    end

    assign o_coord = r_coord6;

endmodule

`default_nettype wire

// File: hw/rtl/depth_pixel_backprojection.sv
// top level: depth pixel to colored 3-D point through a pinhole camera model
// throughput: one pixel beat per cycle; six register stages stall together on o_pt.ready
// zero-depth beats are dropped at the first stage and give no point
// reset clears the stage valid bits and restores the default camera registers
`default_nettype none

module depth_pixel_backprojection (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dpb_pix_if.sink     i_pix,
    dpb_cfg_if.sink     i_cfg,
    dpb_pt_if.source    o_pt
);

    logic [dpb_pkg::PrincW-1:0] r_princ_x;
    logic [dpb_pkg::PrincW-1:0] r_princ_y;
    logic [dpb_pkg::RecipW-1:0] r_recip_fx;
    logic [dpb_pkg::RecipW-1:0] r_recip_fy;
    logic [dpb_pkg::RecipW-1:0] r_recip_scale;

    logic [dpb_pkg::Stages-1:0] r_v;
    logic [dpb_pkg::Stages-1:0] n_v;
    logic                       en;

    dpb_pkg::t_rgb              r_rgb [dpb_pkg::Stages];
    dpb_pkg::t_rgb              n_rgb;
    logic [dpb_pkg::ZW-1:0]     r_zd [dpb_pkg::Stages-2];
    logic [dpb_pkg::ZW-1:0]     z2;

    dpb_pkg::t_axis_cfg         cfg_x;
    dpb_pkg::t_axis_cfg         cfg_y;
    logic signed [dpb_pkg::CoordW-1:0] coord_x;
    logic signed [dpb_pkg::CoordW-1:0] coord_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_princ_x     <= dpb_pkg::PrincXReset;
            r_princ_y     <= dpb_pkg::PrincYReset;
            r_recip_fx    <= dpb_pkg::RecipFxReset;
            r_recip_fy    <= dpb_pkg::RecipFyReset;
            r_recip_scale <= dpb_pkg::RecipScaleReset;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dpb_pkg::RegPrincX: begin
                    r_princ_x <= i_cfg.data[dpb_pkg::PrincW-1:0];
                end
                dpb_pkg::RegPrincY: begin
                    r_princ_y <= i_cfg.data[dpb_pkg::PrincW-1:0];
                end
                dpb_pkg::RegRecipFx: begin
                    r_recip_fx <= i_cfg.data[dpb_pkg::RecipW-1:0];
                end
                dpb_pkg::RegRecipFy: begin
                    r_recip_fy <= i_cfg.data[dpb_pkg::RecipW-1:0];
                end
                dpb_pkg::RegRecipScale: begin
                    r_recip_scale <= i_cfg.data[dpb_pkg::RecipW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // whole pipeline advances while the output register is empty or being taken
    assign en          = !r_v[dpb_pkg::Stages-1] || o_pt.ready;
    assign i_pix.ready = en;

    always_comb begin
        n_v = {r_v[dpb_pkg::Stages-2:0],
               i_pix.valid && (i_pix.depth_raw != dpb_pkg::DepthW'(0))};
        n_rgb.blue  = i_pix.blue_in;
        n_rgb.green = i_pix.green_in;
        n_rgb.red   = i_pix.red_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rgb[0] <= n_rgb;
            for (int s = 1; s < dpb_pkg::Stages; s++) begin
                r_rgb[s] <= r_rgb[s-1];
            end
            r_zd[0] <= z2;
            for (int s = 1; s < dpb_pkg::Stages - 2; s++) begin
                r_zd[s] <= r_zd[s-1];
            end
        end
    end

    dpb_depth u_depth (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_depth       (i_pix.depth_raw),
        .i_recip_scale (r_recip_scale),
        .o_z           (z2)
    );

    assign cfg_x.princ = r_princ_x;
    assign cfg_x.recip = r_recip_fx;
    assign cfg_y.princ = r_princ_y;
    assign cfg_y.recip = r_recip_fy;

    dpb_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pix   (i_pix.column),
        .i_cfg   (cfg_x),
        .i_z     (z2),
        .o_coord (coord_x)
    );

    dpb_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pix   (i_pix.row),
        .i_cfg   (cfg_y),
        .i_z     (z2),
        .o_coord (coord_y)
    );

    assign o_pt.valid     = r_v[dpb_pkg::Stages-1];
    assign o_pt.point_x   = coord_x;
    assign o_pt.point_y   = coord_y;
    assign o_pt.point_z   = r_zd[dpb_pkg::Stages-3];
    assign o_pt.blue_out  = r_rgb[dpb_pkg::Stages-1].blue;
    assign o_pt.green_out = r_rgb[dpb_pkg::Stages-1].green;
    assign o_pt.red_out   = r_rgb[dpb_pkg::Stages-1].red;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the depth pixel back-projector, predicted point by point
`timescale 1ns / 1ps

module testbench;
    import dpb_pkg::*;

    localparam int Latency      = 5;
    localparam int HoldCycles   = 40;
    localparam int TimeoutCycles = 100000;
    localparam int NumRegs      = 5;
    localparam int PhaseItems   = 70;
    localparam int NumPhases    = 7;

    localparam int unsigned PrincMax = (32'd1 << PrincW) - 32'd1;
    localparam int unsigned RecipMax = (32'd1 << RecipW) - 32'd1;
    localparam int unsigned DepthMax = (32'd1 << DepthW) - 32'd1;
    localparam int unsigned PixMax   = (32'd1 << PixW) - 32'd1;
    localparam longint unsigned ZSat     = (64'd1 << ZW) - 1;
    localparam longint unsigned PosSat   = (64'd1 << (CoordW - 1)) - 1;
    localparam longint unsigned NegSat   = 64'd1 << (CoordW - 1);

    typedef enum logic [1:0] {ChkModel, ChkTyped, ChkNone} t_check;

    typedef struct packed {
        logic [DepthW-1:0] depth;
        logic [PixW-1:0]   column;
        logic [PixW-1:0]   row;
        t_rgb              color;
    } t_pixel;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [ZW-1:0]     z;
        t_rgb              color;
    } t_point;

    typedef struct packed {
        logic [PrincW-1:0] princ_x;
        logic [PrincW-1:0] princ_y;
        logic [RecipW-1:0] fx;
        logic [RecipW-1:0] fy;
        logic [RecipW-1:0] scale;
    } t_camera;

    typedef struct packed {
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
    } t_reg_write;

    typedef struct {
        int unsigned cam;
        t_pixel      px;
        t_check      check;
        t_point      want;
    } t_row;

    logic clk;
    logic rst_n;
    bit   tx_idle;
    bit   rx_idle;
    bit   hold_req;
    int   mismatches;
    int   cycles;

    t_camera camera;
    t_camera cams [4];
    t_point  points_due [$];
    t_row    plan [$];

    dpb_pix_if pix_bus ();
    dpb_cfg_if cfg_bus ();
    dpb_pt_if  pt_bus ();

    depth_pixel_backprojection i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_bus),
        .i_cfg   (cfg_bus),
        .o_pt    (pt_bus)
    );

    function automatic logic [CoordW-1:0] project_axis(logic [PixW-1:0] pix,
            logic [PrincW-1:0] princ, longint unsigned z, logic [RecipW-1:0] recip);
        longint unsigned pos;
        longint unsigned mag;
        longint unsigned r;
        bit neg;
        pos = longint'(pix) << FracPixW;
        neg = pos < longint'(princ);
        mag = neg ? longint'(princ) - pos : pos - longint'(princ);
        r = (mag * z * longint'(recip) + (64'd1 << 27)) >> 28;
        if (neg) begin
            if (r > NegSat) r = NegSat;
            return CoordW'(64'd0 - r);
        end
        if (r > PosSat) r = PosSat;
        return CoordW'(r);
    endfunction

    function automatic t_point backproject(t_pixel px, t_camera c);
        t_point p;
        longint unsigned z;
        z = (longint'(px.depth) * longint'(c.scale) + (64'd1 << 7)) >> 8;
        if (z > ZSat) z = ZSat;
        p.x     = project_axis(px.column, c.princ_x, z, c.fx);
        p.y     = project_axis(px.row, c.princ_y, z, c.fy);
        p.z     = ZW'(z);
        p.color = px.color;
        return p;
    endfunction

    function automatic t_row plan_row(int unsigned cam, int unsigned depth,
            int unsigned col, int unsigned rw, logic [23:0] rgb, t_check chk,
            logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic [ZW-1:0] z);
        t_row r;
        r.cam        = cam;
        r.px.depth   = DepthW'(depth);
        r.px.column  = PixW'(col);
        r.px.row     = PixW'(rw);
        r.px.color   = t_rgb'(rgb);
        r.check      = chk;
        r.want.x     = x;
        r.want.y     = y;
        r.want.z     = z;
        r.want.color = t_rgb'(rgb);
        return r;
    endfunction

    function automatic int unsigned pick(int unsigned top, int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return top;
            2, 3: return $urandom_range(0, top);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic t_camera random_camera();
        t_camera c;
        c.princ_x = PrincW'(pick(PrincMax, 1600, 16000));
        c.princ_y = PrincW'(pick(PrincMax, 1600, 12000));
        c.fx      = RecipW'(pick(RecipMax, 11184, 55924));
        c.fy      = RecipW'(pick(RecipMax, 11184, 55924));
        c.scale   = RecipW'(pick(RecipMax, 1677, 33554));
        return c;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        case ($urandom_range(0, 9))
            0: px.depth = '0;
            1: px.depth = DepthW'(1);
            2: px.depth = DepthW'(DepthMax);
            default: px.depth = DepthW'($urandom_range(1, DepthMax));
        endcase
        px.column = PixW'($urandom_range(0, PixMax));
        px.row    = PixW'($urandom_range(0, PixMax));
        px.color  = t_rgb'(24'($urandom));
        return px;
    endfunction

    task automatic report(string field, longint got, longint want);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch on %s: got %0d, want %0d", field, got, want);
    endtask

    task automatic send_pixel(input t_pixel px, input t_check check, input t_point want);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_bus.valid     <= 1'b1;
        pix_bus.depth_raw <= px.depth;
        pix_bus.column    <= px.column;
        pix_bus.row       <= px.row;
        pix_bus.blue_in   <= px.color.blue;
        pix_bus.green_in  <= px.color.green;
        pix_bus.red_in    <= px.color.red;
        do @(posedge clk); while (!pix_bus.ready);
        case (check)
            ChkModel: if (px.depth != '0)
                points_due.insert(points_due.size(), backproject(px, camera));
            ChkTyped: points_due.insert(points_due.size(), want);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (points_due.size() != 0) @(posedge clk);
        repeat (Latency + 3) @(posedge clk);
    endtask

    task automatic apply_camera(input t_camera c);
        t_reg_write writes [$];
        t_reg_write extra;
        logic [CfgDataW-PrincW-1:0] junk_x;
        logic [CfgDataW-PrincW-1:0] junk_y;
        junk_x = ($urandom_range(0, 1) == 0) ? '0 : (CfgDataW - PrincW)'($urandom);
        junk_y = (CfgDataW - PrincW)'($urandom);
        writes = '{t_reg_write'{RegPrincX, {junk_x, c.princ_x}},
                   t_reg_write'{RegPrincY, {junk_y, c.princ_y}},
                   t_reg_write'{RegRecipFx, c.fx},
                   t_reg_write'{RegRecipFy, c.fy},
                   t_reg_write'{RegRecipScale, c.scale}};
        extra.idx  = CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1));
        extra.data = CfgDataW'($urandom);
        writes.insert($urandom_range(0, writes.size()), extra);
        foreach (writes[i]) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= writes[i].idx;
            cfg_bus.data  <= writes[i].data;
            do @(posedge clk); while (!cfg_bus.ready);
            case (writes[i].idx)
                RegPrincX:     camera.princ_x = writes[i].data[PrincW-1:0];
                RegPrincY:     camera.princ_y = writes[i].data[PrincW-1:0];
                RegRecipFx:    camera.fx      = writes[i].data[RecipW-1:0];
                RegRecipFy:    camera.fy      = writes[i].data[RecipW-1:0];
                RegRecipScale: camera.scale   = writes[i].data[RecipW-1:0];
                default: ;
            endcase
        end
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < TimeoutCycles) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : drive_ready
        pt_bus.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pt_bus.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                pt_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            pt_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_points
        t_point want;
        if (rst_n && pt_bus.valid && pt_bus.ready) begin
            if (points_due.size() == 0) begin
                report("unexpected point_z", longint'(pt_bus.point_z), -1);
            end else begin
                want = points_due.pop_front();
                if (pt_bus.point_x !== want.x)
                    report("point_x", longint'(pt_bus.point_x), longint'($signed(want.x)));
                if (pt_bus.point_y !== want.y)
                    report("point_y", longint'(pt_bus.point_y), longint'($signed(want.y)));
                if (pt_bus.point_z !== want.z)
                    report("point_z", longint'(pt_bus.point_z), longint'(want.z));
                if (pt_bus.blue_out !== want.color.blue)
                    report("blue_out", longint'(pt_bus.blue_out), longint'(want.color.blue));
                if (pt_bus.green_out !== want.color.green)
                    report("green_out", longint'(pt_bus.green_out), longint'(want.color.green));
                if (pt_bus.red_out !== want.color.red)
                    report("red_out", longint'(pt_bus.red_out), longint'(want.color.red));
            end
        end
    end

    initial begin : stimulus
        int unsigned cur_cam;
        mismatches = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        hold_req   = 1'b0;
        camera     = '{PrincXReset, PrincYReset, RecipFxReset, RecipFyReset, RecipScaleReset};
        cams[0]    = camera;
        cams[1]    = '{'0, PrincW'(PrincMax), RecipW'(RecipMax), RecipW'(RecipMax),
                       RecipW'(RecipMax)};
        cams[2]    = '0;
        cams[3]    = '{PrincW'(PrincMax), '0, RecipW'(RecipMax), RecipW'(RecipMax),
                       RecipW'(RecipMax)};
        plan = '{
            // reset camera
            plan_row(0, 0, 325, 253, 24'h102030, ChkNone, '0, '0, '0),
            plan_row(0, 1000, 325, 253, 24'h112233, ChkModel, '0, '0, '0),
            plan_row(0, 1000, 326, 254, 24'h445566, ChkModel, '0, '0, '0),
            plan_row(0, 65535, 2047, 2047, 24'hFFFFFF, ChkModel, '0, '0, '0),
            plan_row(0, 1, 0, 0, 24'h000000, ChkModel, '0, '0, '0),
            plan_row(0, 0, 2047, 2047, 24'hFFFFFF, ChkNone, '0, '0, '0),
            // saturation, positive x and negative y
            plan_row(1, 65535, 2047, 0, 24'h8040C0, ChkTyped,
                     24'h7FFFFF, 24'h800000, 23'h7FFFFF),
            plan_row(1, 1, 0, 2047, 24'h010203, ChkModel, '0, '0, '0),
            plan_row(1, 32768, 1024, 1024, 24'hFE7F01, ChkModel, '0, '0, '0),
            // zero reciprocals give the origin
            plan_row(2, 65535, 2047, 2047, 24'hA55AC3, ChkTyped, '0, '0, '0),
            plan_row(2, 1, 0, 0, 24'h5AA53C, ChkTyped, '0, '0, '0),
            // saturation, negative x and positive y
            plan_row(3, 65535, 0, 2047, 24'h0F0FF0, ChkTyped,
                     24'h800000, 24'h7FFFFF, 23'h7FFFFF),
            plan_row(3, 43690, 1365, 682, 24'hAA55AA, ChkModel, '0, '0, '0),
            plan_row(3, 21845, 682, 1365, 24'h55AA55, ChkModel, '0, '0, '0)
        };

        rst_n <= 1'b0;
        pix_bus.valid     <= 1'b0;
        pix_bus.depth_raw <= '0;
        pix_bus.column    <= '0;
        pix_bus.row       <= '0;
        pix_bus.blue_in   <= '0;
        pix_bus.green_in  <= '0;
        pix_bus.red_in    <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= '0;
        cfg_bus.data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        cur_cam = 0;
        foreach (plan[i]) begin
            if (plan[i].cam != cur_cam) begin
                wait_idle();
                apply_camera(cams[plan[i].cam]);
                cur_cam = plan[i].cam;
            end
            send_pixel(plan[i].px, plan[i].check, plan[i].want);
        end

        for (int p = 0; p < NumPhases; p++) begin
            wait_idle();
            apply_camera(p == NumPhases - 1 ? cams[0] : random_camera());
            tx_idle = (p < NumPhases - 1) && (p % 3 != 2);
            rx_idle = (p < NumPhases - 1) && (p % 3 != 1);
            // receiver holds off while the sender keeps the pipe full
            if (p == 2) hold_req = 1'b1;
            repeat (p == NumPhases - 1 ? 40 : PhaseItems)
                send_pixel(random_pixel(), ChkModel, '0);
        end
        wait_idle();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
